/* rtl/clpm_pkg.sv */
`default_nettype none
package clpm_pkg;

	localparam int MAX_PROCESSORS = 64;
	localparam int NANOSECONDS_PER_TICK = 10000000;
	localparam int SLOT_COUNT = MAX_PROCESSORS + 1;
	localparam int ADDR_W = $clog2(SLOT_COUNT);
	localparam int COUNTER_COUNT = 7;
	localparam int CNT_IDX_W = $clog2(COUNTER_COUNT);
	localparam int IDLE_IDX = 3;
	localparam int IOWAIT_IDX = 4;

	localparam int SCALE_NUM = 100000;
	localparam int SCALE_W = $clog2(SCALE_NUM + 1);
	localparam int PCT_DIV = 10;
	localparam int HUND_DIV = 100;

	// divisor must hold both the tick length and the scale numerator
	localparam int TICK_W = $clog2(NANOSECONDS_PER_TICK + 1);
	localparam int DIV_W = (TICK_W > SCALE_W) ? TICK_W : SCALE_W;
	localparam int REM_W = DIV_W + 1;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYCLES = 64 / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

	localparam int IN_DATA_W = 64 * COUNTER_COUNT;
	localparam int OUT_DATA_W = 16;

endpackage
`default_nettype wire

/* rtl/cpu_load_percent_monitor_top.sv */
`default_nettype none
// Busy-load monitor: each transaction carries one processor's seven cumulative
// nanosecond counters; the block returns that processor's busy percentage
// since its previous sample, and on a tlast transaction also the percentage of
// the round's aggregate (slot 0), after which the aggregate sums are cleared.
// Work is sequential on one shared radix-16 restoring divider: seven tick
// conversions, then up to three more divisions for the scaling. Previous
// totals live in a 65-entry memory with a registered read; entries read as
// zero until first written.
module cpu_load_percent_monitor_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// user_ns, nice_ns, system_ns, idle_ns, iowait_ns, irq_ns, softirq_ns
	input  wire logic [clpm_pkg::IN_DATA_W-1:0]   s_tdata,
	// cpu_index
	input  wire logic [5:0]                       s_tuser,
	input  wire logic                             s_tlast,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// load_whole[6:0], load_hundredths[13:7], zero_interval[14], zero pad
	output logic [clpm_pkg::OUT_DATA_W-1:0]       m_tdata,
	// slot
	output logic [6:0]                            m_tuser,
	output logic                                  m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADD, ST_EV_START, ST_DIV_TICK, ST_TOTALS, ST_CHECK,
		ST_SCALE, ST_MUL, ST_PREP10, ST_DIV10, ST_DIV100, ST_EMIT
	} state_t;

	state_t state_q;

	logic [63:0] cnt_q [clpm_pkg::COUNTER_COUNT];
	logic [63:0] sum_q [clpm_pkg::COUNTER_COUNT];
	logic [5:0]  cpu_q;
	logic        final_q;
	logic        agg_q;
	logic [6:0]  slot_q;
	logic [clpm_pkg::CNT_IDX_W-1:0] k_q;
	logic [63:0] nt_q, ni_q, total_q, idle_q;
	logic [clpm_pkg::SCALE_W-1:0] scale_q, prod_q;
	logic [6:0]  whole_q, hund_q;
	logic        zero_q;

	// divider
	logic [63:0] dq_q;
	logic [clpm_pkg::REM_W-1:0] dr_q;
	logic [clpm_pkg::DIV_W-1:0] dd_q;
	logic [clpm_pkg::DIV_CNT_W-1:0] dc_q;
	logic [63:0] dq_n;
	logic [clpm_pkg::REM_W-1:0] dr_n;
	logic        div_last;

	// previous-value memory: {total, idle}
	logic [127:0] mem [clpm_pkg::SLOT_COUNT];
	logic [127:0] rd_q;
	logic [clpm_pkg::SLOT_COUNT-1:0] vld_q;
	logic [clpm_pkg::ADDR_W-1:0] addr;
	logic        we;
	logic [63:0] prev_t, prev_i, idle_c;
	logic [33:0] mul_full;
	logic        in_range;

	assign addr = clpm_pkg::ADDR_W'(slot_q);
	assign we = (state_q == ST_TOTALS);
	assign prev_t = vld_q[addr] ? rd_q[127:64] : 64'd0;
	assign prev_i = vld_q[addr] ? rd_q[63:0] : 64'd0;
	assign in_range = {3'b000, s_tuser} < 9'(clpm_pkg::MAX_PROCESSORS);
	assign idle_c = (idle_q > total_q) ? total_q : idle_q;
	assign mul_full = 34'(idle_c[clpm_pkg::SCALE_W-1:0]) * 34'(scale_q);
	assign div_last = (dc_q == clpm_pkg::DIV_CNT_W'(clpm_pkg::DIV_CYCLES - 1));
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		logic [63:0] q;
		logic [clpm_pkg::REM_W-1:0] r;
		q = dq_q;
		r = dr_q;
		for (int i = 0; i < clpm_pkg::DIV_STEPS; i++) begin
			r = {r[clpm_pkg::REM_W-2:0], q[63]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, dd_q}) begin
				r = r - {1'b0, dd_q};
				q[0] = 1'b1;
			end
		end
		dq_n = q;
		dr_n = r;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= {nt_q, ni_q};
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (we)
			vld_q[addr] <= 1'b1;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			for (int i = 0; i < clpm_pkg::COUNTER_COUNT; i++)
				cnt_q[i] <= s_tdata[64*i +: 64];
			cpu_q <= s_tuser;
			final_q <= s_tlast;
		end
		dq_q <= dq_n;
		dr_q <= dr_n;
		dc_q <= dc_q + 1'b1;
		case (state_q)
			ST_EV_START: begin
				k_q <= '0;
				nt_q <= '0;
				ni_q <= '0;
				dq_q <= agg_q ? sum_q[0] : cnt_q[0];
				dr_q <= '0;
				dd_q <= clpm_pkg::DIV_W'(clpm_pkg::NANOSECONDS_PER_TICK);
				dc_q <= '0;
			end
			ST_DIV_TICK: begin
				if (div_last) begin
					nt_q <= nt_q + dq_n;
					if (k_q == clpm_pkg::CNT_IDX_W'(clpm_pkg::IDLE_IDX) ||
					    k_q == clpm_pkg::CNT_IDX_W'(clpm_pkg::IOWAIT_IDX))
						ni_q <= ni_q + dq_n;
					k_q <= k_q + 1'b1;
					dq_q <= agg_q ? sum_q[k_q + 1'b1] : cnt_q[k_q + 1'b1];
					dr_q <= '0;
					dc_q <= '0;
				end
			end
			ST_TOTALS: begin
				total_q <= nt_q - prev_t;
				idle_q <= ni_q - prev_i;
			end
			ST_CHECK: begin
				zero_q <= (total_q == 64'd0);
				whole_q <= '0;
				hund_q <= '0;
				scale_q <= '0;
				dq_q <= 64'(clpm_pkg::SCALE_NUM);
				dr_q <= '0;
				dd_q <= total_q[clpm_pkg::DIV_W-1:0];
				dc_q <= '0;
			end
			ST_SCALE: begin
				if (div_last)
					scale_q <= dq_n[clpm_pkg::SCALE_W-1:0];
			end
			ST_MUL: prod_q <= mul_full[clpm_pkg::SCALE_W-1:0];
			ST_PREP10: begin
				dq_q <= 64'(clpm_pkg::SCALE_W'(clpm_pkg::SCALE_NUM) - prod_q);
				dr_q <= '0;
				dd_q <= clpm_pkg::DIV_W'(clpm_pkg::PCT_DIV);
				dc_q <= '0;
			end
			ST_DIV10: begin
				if (div_last) begin
					dq_q <= dq_n;
					dr_q <= '0;
					dd_q <= clpm_pkg::DIV_W'(clpm_pkg::HUND_DIV);
					dc_q <= '0;
				end
			end
			ST_DIV100: begin
				if (div_last) begin
					whole_q <= dq_n[6:0];
					hund_q <= dr_n[6:0];
				end
			end
			default: ;
		endcase
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			agg_q <= 1'b0;
			slot_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			m_tlast <= 1'b0;
			for (int i = 0; i < clpm_pkg::COUNTER_COUNT; i++)
				sum_q[i] <= '0;
		end else begin
			if (m_tready && state_q != ST_EMIT)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (in_range) begin
							state_q <= ST_ADD;
						end else if (s_tlast) begin
							agg_q <= 1'b1;
							slot_q <= '0;
							state_q <= ST_EV_START;
						end
					end
				end
				ST_ADD: begin
					for (int i = 0; i < clpm_pkg::COUNTER_COUNT; i++)
						sum_q[i] <= sum_q[i] + cnt_q[i];
					agg_q <= 1'b0;
					slot_q <= {1'b0, cpu_q} + 7'd1;
					state_q <= ST_EV_START;
				end
				ST_EV_START: state_q <= ST_DIV_TICK;
				ST_DIV_TICK: begin
					if (div_last &&
					    k_q == clpm_pkg::CNT_IDX_W'(clpm_pkg::COUNTER_COUNT - 1))
						state_q <= ST_TOTALS;
				end
				ST_TOTALS: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (total_q == 64'd0)
						state_q <= ST_EMIT;
					else if (total_q > 64'(clpm_pkg::SCALE_NUM))
						state_q <= ST_MUL;
					else
						state_q <= ST_SCALE;
				end
				ST_SCALE: if (div_last) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_PREP10;
				ST_PREP10: state_q <= ST_DIV10;
				ST_DIV10: if (div_last) state_q <= ST_DIV100;
				ST_DIV100: if (div_last) state_q <= ST_EMIT;
				ST_EMIT: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {1'b0, zero_q, hund_q, whole_q};
						m_tuser <= slot_q;
						m_tlast <= agg_q;
						if (agg_q) begin
							for (int i = 0; i < clpm_pkg::COUNTER_COUNT; i++)
								sum_q[i] <= '0;
							state_q <= ST_IDLE;
						end else if (final_q) begin
							agg_q <= 1'b1;
							slot_q <= '0;
							state_q <= ST_EV_START;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* verif/tb_cpu_load_percent_monitor_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_cpu_load_percent_monitor_top;

	localparam longint unsigned TICK_NS = clpm_pkg::NANOSECONDS_PER_TICK;
	localparam int ITEM_TARGET = 2000;
	localparam int QUIET_TAIL = 200;

	typedef struct {
		logic [5:0]   cpu;
		logic [447:0] data;
		logic         last;
	} sample_t;

	typedef struct {
		logic [6:0] slot;
		logic [6:0] whole;
		logic [6:0] hund;
		logic       zero;
		logic       rnd_end;
	} load_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [clpm_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [5:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [clpm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [6:0] m_tuser;
	logic m_tlast;

	sample_t samples_q[$];
	load_t pending_loads_q[$];
	logic [63:0] prev_total[clpm_pkg::SLOT_COUNT];
	logic [63:0] last_idle[clpm_pkg::SLOT_COUNT];
	logic [63:0] agg_sum[clpm_pkg::COUNTER_COUNT];
	logic [63:0] cum[64][clpm_pkg::COUNTER_COUNT];
	int total_items = 0;
	int sent_cnt = 0;
	int result_cnt = 0;
	int zero_cnt = 0;
	int round_cnt = 0;
	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	logic rx_hold = 1'b0;

	always #10 clk = ~clk;

	cpu_load_percent_monitor_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// compute one slot's busy load and update its stored ticks
	function automatic void eval_load(int slot, logic [447:0] ns, logic rnd_end);
		logic [63:0] now_total;
		logic [63:0] now_idle;
		logic [63:0] tot;
		logic [63:0] idl;
		logic [63:0] scale;
		logic [63:0] pct;
		load_t r;
		now_total = '0;
		for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++)
			now_total += ns[64*k +: 64] / TICK_NS;
		now_idle = ns[64*clpm_pkg::IDLE_IDX +: 64] / TICK_NS
			+ ns[64*clpm_pkg::IOWAIT_IDX +: 64] / TICK_NS;
		tot = now_total - prev_total[slot];
		idl = now_idle - last_idle[slot];
		prev_total[slot] = now_total;
		last_idle[slot] = now_idle;
		r.slot = 7'(slot);
		r.rnd_end = rnd_end;
		if (tot == 0) begin
			r.whole = '0;
			r.hund = '0;
			r.zero = 1'b1;
		end else begin
			scale = 64'd100000 / tot;
			if (idl > tot)
				idl = tot;
			pct = (64'd100000 - idl * scale) / 64'd10;
			r.whole = 7'(pct / 64'd100);
			r.hund = 7'(pct % 64'd100);
			r.zero = 1'b0;
		end
		pending_loads_q.push_back(r);
	endfunction

	function automatic void predict_load(sample_t s);
		logic [447:0] agg;
		if (int'(s.cpu) < clpm_pkg::MAX_PROCESSORS) begin
			for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++)
				agg_sum[k] += s.data[64*k +: 64];
			eval_load(int'(s.cpu) + 1, s.data, 1'b0);
		end
		if (s.last) begin
			for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++) begin
				agg[64*k +: 64] = agg_sum[k];
				agg_sum[k] = '0;
			end
			eval_load(0, agg, 1'b1);
		end
	endfunction

	function automatic void add_sample(int cpu, logic [447:0] data, logic last);
		sample_t s;
		s.cpu = 6'(cpu);
		s.data = data;
		s.last = last;
		samples_q.push_back(s);
	endfunction

	// advance one processor's counters; mode 1 holds, mode 2 sets counter 0 back
	function automatic logic [447:0] step_counters(int cpu, int mode);
		logic [447:0] d;
		for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++) begin
			if (mode == 1)
				;
			else if (mode == 2 && k == 0)
				cum[cpu][k] -= 64'($urandom_range(1, 50)) * TICK_NS;
			else
				cum[cpu][k] += 64'($urandom_range(0, 30)) * TICK_NS
					+ 64'($urandom_range(0, TICK_NS - 1));
			d[64*k +: 64] = cum[cpu][k];
		end
		return d;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_load('{cpu: s_tuser, data: s_tdata, last: s_tlast});
				sent_cnt <= sent_cnt + 1;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered transaction
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (samples_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
				tx_gap <= $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else if (samples_q.size() > 0) begin
				s_tuser <= samples_q[0].cpu;
				s_tdata <= samples_q[0].data;
				s_tlast <= samples_q[0].last;
				s_tvalid <= 1'b1;
				void'(samples_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls and monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else if (samples_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
				rx_gap <= $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_hold;
			end
			if (m_tvalid && m_tready) begin
				result_cnt <= result_cnt + 1;
				if (pending_loads_q.size() == 0) begin
					$error("unexpected result slot=%0d", m_tuser);
					errors = errors + 1;
				end else begin
					if (m_tuser !== pending_loads_q[0].slot) begin
						$error("slot exp=%0d act=%0d", pending_loads_q[0].slot, m_tuser);
						errors = errors + 1;
					end
					if (m_tdata[6:0] !== pending_loads_q[0].whole) begin
						$error("load_whole exp=%0d act=%0d",
							pending_loads_q[0].whole, m_tdata[6:0]);
						errors = errors + 1;
					end
					if (m_tdata[13:7] !== pending_loads_q[0].hund) begin
						$error("load_hundredths exp=%0d act=%0d",
							pending_loads_q[0].hund, m_tdata[13:7]);
						errors = errors + 1;
					end
					if (m_tdata[14] !== pending_loads_q[0].zero) begin
						$error("zero_interval exp=%0d act=%0d",
							pending_loads_q[0].zero, m_tdata[14]);
						errors = errors + 1;
					end
					if (m_tlast !== pending_loads_q[0].rnd_end) begin
						$error("round_end exp=%0d act=%0d",
							pending_loads_q[0].rnd_end, m_tlast);
						errors = errors + 1;
					end
					if (pending_loads_q[0].zero)
						zero_cnt <= zero_cnt + 1;
					if (pending_loads_q[0].rnd_end)
						round_cnt <= round_cnt + 1;
					void'(pending_loads_q.pop_front());
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (sent_cnt >= 100);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (4000) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#100ms;
		$display("tb_cpu_load_percent_monitor_top failed");
		$finish;
	end

	initial begin
		logic [447:0] d;
		int n;
		int mode;
		for (int i = 0; i < clpm_pkg::SLOT_COUNT; i++) begin
			prev_total[i] = '0;
			last_idle[i] = '0;
		end
		for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++)
			agg_sum[k] = '0;
		for (int c = 0; c < 64; c++)
			for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++)
				cum[c][k] = '0;

		// directed: zero interval, all ones, large interval, idle above total, wrap
		add_sample(0, '0, 1'b0);
		add_sample(0, '0, 1'b1);
		add_sample(63, '1, 1'b0);
		add_sample(62, '1, 1'b1);
		add_sample(63, '1, 1'b1);
		d = '0;
		d[63:0] = 64'd1 << 40;
		add_sample(1, d, 1'b0);
		d = '0;
		d[64*clpm_pkg::IDLE_IDX +: 64] = 64'd500 * TICK_NS;
		add_sample(2, d, 1'b0);
		d[64*clpm_pkg::IDLE_IDX +: 64] = 64'd700 * TICK_NS;
		d[63:0] = 64'd300 * TICK_NS;
		add_sample(2, d, 1'b0);
		d[63:0] = 64'd100 * TICK_NS;
		d[64*clpm_pkg::IDLE_IDX +: 64] = 64'd750 * TICK_NS;
		add_sample(2, d, 1'b1);
		d = '0;
		d[64*clpm_pkg::IOWAIT_IDX +: 64] = 64'd40 * TICK_NS;
		d[64*5 +: 64] = 64'd60 * TICK_NS + TICK_NS - 1;
		add_sample(3, d, 1'b0);
		d[64*6 +: 64] = 64'd33 * TICK_NS;
		add_sample(3, d, 1'b1);
		add_sample(3, d, 1'b1);
		add_sample(0, '0, 1'b0);

		// random: rounds of well-formed samples, some noise and broken rounds
		while (samples_q.size() < ITEM_TARGET) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 6);
			repeat ($urandom_range(2, 8)) begin
				for (int c = 0; c < n; c++) begin
					mode = $urandom_range(0, 19);
					if (mode == 0) begin
						for (int k = 0; k < clpm_pkg::COUNTER_COUNT; k++)
							d[64*k +: 64] = rand64();
						add_sample($urandom_range(0, 63), d, $urandom_range(0, 1));
					end else begin
						d = step_counters(c, (mode == 1) ? 1 : (mode == 2) ? 2 : 0);
						add_sample(c, d, (c == n - 1) || ($urandom_range(0, 29) == 0));
					end
				end
			end
		end
		total_items = samples_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (samples_q.size() == 0 && sent_cnt == total_items);
		wait (pending_loads_q.size() == 0);
		repeat (400) @(posedge clk);
		if (pending_loads_q.size() != 0)
			errors = errors + 1;
		$display("covered %0d samples, %0d loads checked", sent_cnt, result_cnt);
		$display("  including %0d round aggregates and %0d zero intervals",
			round_cnt, zero_cnt);
		if (errors == 0)
			$display("tb_cpu_load_percent_monitor_top passed");
		else
			$display("tb_cpu_load_percent_monitor_top failed");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
rtl/clpm_pkg.sv
rtl/cpu_load_percent_monitor_top.sv
verif/tb_cpu_load_percent_monitor_top.sv
